FILE: rtl/cpfr_pkg.sv
package cpfr_pkg;

   localparam int CAPACITY = 32;

   localparam int KIND_W   = 2;
   localparam int BYTE_W   = 8;
   localparam int EVENT_W  = 3;
   localparam int INDEX_W  = 5;
   localparam int DATA_W   = 7;
   localparam int FCOUNT_W = 6;
   localparam int TOTAL_W  = 7;
   localparam int TICK_W   = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [TICK_W-1:0]  TIMEOUT_RESET = 16'd1000;
   localparam logic [TOTAL_W-1:0] CAP_TOTAL     = TOTAL_W'(CAPACITY);

   localparam logic [KIND_W-1:0] KIND_BYTE   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TICK   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_BUTTON = 2'd2;

   localparam logic [EVENT_W-1:0] EV_NONE    = 3'd0;
   localparam logic [EVENT_W-1:0] EV_STATUS  = 3'd1;
   localparam logic [EVENT_W-1:0] EV_STORED  = 3'd2;
   localparam logic [EVENT_W-1:0] EV_DONE    = 3'd3;
   localparam logic [EVENT_W-1:0] EV_BAD     = 3'd4;
   localparam logic [EVENT_W-1:0] EV_TIMEOUT = 3'd5;

   localparam logic [CSR_ADDR_W-1:0] CSR_TIMEOUT_ADDR = 3'd0;

   typedef struct packed {
      logic [EVENT_W-1:0]  event_res;
      logic [INDEX_W-1:0]  value_index;
      logic [DATA_W-1:0]   value_data;
      logic [FCOUNT_W-1:0] frame_count;
      logic                status_byte;
   } result_type;

endpackage

FILE: rtl/cpfr_core.sv
module cpfr_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              accept,
   input  logic [cpfr_pkg::KIND_W-1:0]       kind,
   input  logic [cpfr_pkg::BYTE_W-1:0]       rx_byte,
   input  logic                              button_level,
   input  logic [cpfr_pkg::TICK_W-1:0]       timeout_ticks,
   output cpfr_pkg::result_type              result
);

   logic                              in_data_phase_ff, in_data_phase_in;
   logic [cpfr_pkg::TOTAL_W-1:0]      expected_total_ff, expected_total_in;
   logic [cpfr_pkg::TOTAL_W-1:0]      received_total_ff, received_total_in;
   logic [cpfr_pkg::TICK_W-1:0]       phase_elapsed_ff, phase_elapsed_in;
   logic                              monitor_on_ff, monitor_on_in;
   logic                              prev_button_ff, prev_button_in;

   logic [cpfr_pkg::TOTAL_W-1:0]      clamped;
   logic [cpfr_pkg::TOTAL_W-1:0]      rx_low;
   logic [cpfr_pkg::TOTAL_W-1:0]      received_next;
   logic [cpfr_pkg::TICK_W-1:0]       elapsed_next;
   logic                              slot_stored;

   assign rx_low        = rx_byte[cpfr_pkg::TOTAL_W-1:0];
   assign clamped       = (expected_total_ff > cpfr_pkg::CAP_TOTAL) ?
                          cpfr_pkg::CAP_TOTAL : expected_total_ff;
   assign received_next = received_total_ff + 1'b1;
   assign slot_stored   = received_total_ff < cpfr_pkg::CAP_TOTAL;
   assign elapsed_next  = (phase_elapsed_ff == '1) ? phase_elapsed_ff
                                                   : phase_elapsed_ff + 1'b1;

   always_comb begin
      in_data_phase_in  = in_data_phase_ff;
      expected_total_in = expected_total_ff;
      received_total_in = received_total_ff;
      phase_elapsed_in  = phase_elapsed_ff;
      monitor_on_in     = monitor_on_ff;
      prev_button_in    = prev_button_ff;
      result            = '0;

      case (kind)
         cpfr_pkg::KIND_BYTE: begin
            if (!in_data_phase_ff) begin
               if (rx_byte[cpfr_pkg::BYTE_W-1] && (rx_low != '0)) begin
                  expected_total_in = rx_low;
                  in_data_phase_in  = 1'b1;
                  received_total_in = '0;
                  phase_elapsed_in  = '0;
               end
            end else if (rx_byte[cpfr_pkg::BYTE_W-1]) begin
               result.event_res  = cpfr_pkg::EV_BAD;
               in_data_phase_in  = 1'b0;
               received_total_in = '0;
               phase_elapsed_in  = '0;
            end else begin
               received_total_in  = received_next;
               result.frame_count = clamped[cpfr_pkg::FCOUNT_W-1:0];
               if (slot_stored) begin
                  result.value_index = received_total_ff[cpfr_pkg::INDEX_W-1:0];
                  result.value_data  = rx_byte[cpfr_pkg::DATA_W-1:0];
               end
               if (received_next >= expected_total_ff) begin
                  result.event_res  = cpfr_pkg::EV_DONE;
                  in_data_phase_in  = 1'b0;
                  received_total_in = '0;
                  phase_elapsed_in  = '0;
               end else if (slot_stored) begin
                  result.event_res = cpfr_pkg::EV_STORED;
               end else begin
                  result.frame_count = '0;
               end
            end
         end
         cpfr_pkg::KIND_TICK: begin
            phase_elapsed_in = elapsed_next;
            if (elapsed_next > timeout_ticks) begin
               result.event_res  = cpfr_pkg::EV_TIMEOUT;
               in_data_phase_in  = 1'b0;
               received_total_in = '0;
               phase_elapsed_in  = '0;
            end
         end
         cpfr_pkg::KIND_BUTTON: begin
            if (button_level && !prev_button_ff) begin
               monitor_on_in = !monitor_on_ff;
            end
            prev_button_in   = button_level;
            result.event_res = cpfr_pkg::EV_STATUS;
         end
         default: begin
         end
      endcase

      result.status_byte = monitor_on_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_data_phase_ff  <= 1'b0;
         expected_total_ff <= '0;
         received_total_ff <= '0;
         phase_elapsed_ff  <= '0;
         monitor_on_ff     <= 1'b1;
         prev_button_ff    <= 1'b0;
      end else if (accept) begin
         in_data_phase_ff  <= in_data_phase_in;
         expected_total_ff <= expected_total_in;
         received_total_ff <= received_total_in;
         phase_elapsed_ff  <= phase_elapsed_in;
         monitor_on_ff     <= monitor_on_in;
         prev_button_ff    <= prev_button_in;
      end
   end

endmodule

FILE: rtl/cpfr_rsp_queue.sv
module cpfr_rsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  cpfr_pkg::result_type push_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output cpfr_pkg::result_type head
);

   cpfr_pkg::result_type head_ff, head_in;
   cpfr_pkg::result_type tail_ff, tail_in;
   logic                 head_vld_ff, head_vld_in;
   logic                 tail_vld_ff, tail_vld_in;
   logic                 pop;

   assign pop       = head_vld_ff && !rsp_stall;
   assign full      = tail_vld_ff;
   assign rsp_valid = head_vld_ff;
   assign head      = head_ff;

   // push must be given only while the tail slot is empty; the queue itself does not enforce it
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      head_vld_in = head_vld_ff;
      tail_vld_in = tail_vld_ff;
      if (pop) begin
         head_in     = tail_vld_ff ? tail_ff : push_data;
         head_vld_in = tail_vld_ff || push;
         tail_vld_in = 1'b0;
      end else if (push) begin
         if (head_vld_ff) begin
            tail_in     = push_data;
            tail_vld_in = 1'b1;
         end else begin
            head_in     = push_data;
            head_vld_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
      if (reset) begin
         head_vld_ff <= 1'b0;
         tail_vld_ff <= 1'b0;
      end else begin
         head_vld_ff <= head_vld_in;
         tail_vld_ff <= tail_vld_in;
      end
   end

endmodule

FILE: rtl/count_prefixed_frame_receiver_unit.sv
// Each accepted transaction's result is registered into the result queue and shows on rsp_valid.
// Throughput: one transaction per cycle while req_stall is low; the phase state updates in a single pass.
// A two-entry result queue holds results while rsp_stall is high; req_stall rises
// only when both entries are full.
// Reset (synchronous, active high): hunting, counters cleared, monitor on,
// timeout_ticks back to 1000, result queue empty.
module count_prefixed_frame_receiver_unit (
   input  logic                                clock,
   input  logic                                reset,

   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [cpfr_pkg::KIND_W-1:0]         req_kind,
   input  logic [cpfr_pkg::BYTE_W-1:0]         req_rx_byte,
   input  logic                                req_button_level,

   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [cpfr_pkg::EVENT_W-1:0]        rsp_event_res,
   output logic [cpfr_pkg::INDEX_W-1:0]        rsp_value_index,
   output logic [cpfr_pkg::DATA_W-1:0]         rsp_value_data,
   output logic [cpfr_pkg::FCOUNT_W-1:0]       rsp_frame_count,
   output logic                                rsp_status_byte,

   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [cpfr_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [cpfr_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [cpfr_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   logic [cpfr_pkg::TICK_W-1:0] timeout_ff;
   logic                        accept;
   logic                        queue_full;
   logic                        csr_write;
   cpfr_pkg::result_type        result;
   cpfr_pkg::result_type        head;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;
   assign prdata    = (paddr[cpfr_pkg::CSR_ADDR_W-1] == cpfr_pkg::CSR_TIMEOUT_ADDR[2]) ?
                      cpfr_pkg::CSR_DATA_W'(timeout_ff) : '0;

   // low address bits ignored: a register occupies a whole word
   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= cpfr_pkg::TIMEOUT_RESET;
      end else if (csr_write &&
                   (paddr[cpfr_pkg::CSR_ADDR_W-1] == cpfr_pkg::CSR_TIMEOUT_ADDR[2])) begin
         timeout_ff <= pwdata[cpfr_pkg::TICK_W-1:0];
      end
   end

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   cpfr_core u_core (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .kind          (req_kind),
      .rx_byte       (req_rx_byte),
      .button_level  (req_button_level),
      .timeout_ticks (timeout_ff),
      .result        (result)
   );

   cpfr_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .head      (head)
   );

   assign rsp_event_res   = head.event_res;
   assign rsp_value_index = head.value_index;
   assign rsp_value_data  = head.value_data;
   assign rsp_frame_count = head.frame_count;
   assign rsp_status_byte = head.status_byte;

`ifndef SYNTHESIS
   a_stall_needs_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no pending result");

   a_stored_in_frame: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res == cpfr_pkg::EV_STORED)) |->
      ({1'b0, rsp_value_index} < rsp_frame_count))
      else $error("stored slot beyond frame count");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid)
      else $error("accepted transaction produced no result");

   a_idle_fields_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_event_res != cpfr_pkg::EV_STORED) &&
       (rsp_event_res != cpfr_pkg::EV_DONE)) |->
      ((rsp_frame_count == '0) && (rsp_value_index == '0) && (rsp_value_data == '0)))
      else $error("frame fields set outside value events");
`endif

endmodule

FILE: tb/tb_count_prefixed_frame_receiver_unit.sv
module tb_count_prefixed_frame_receiver_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [cpfr_pkg::KIND_W-1:0] KIND_SPARE  = 2'd3;
   localparam logic [cpfr_pkg::BYTE_W-1:0] HEADER_FLAG = 8'h80;
   localparam int IDLE_PCT    = 22;
   localparam int HOLD_CYCLES = 60;
   localparam int MAX_SHOWN   = 10;

   // Tracks the frame receiver state and queues the result each transaction should give.
   class frame_scoreboard;
      cpfr_pkg::result_type                expected_q[$];
      logic [cpfr_pkg::TICK_W-1:0]         timeout_ticks;
      logic                                in_frame;
      logic [cpfr_pkg::TOTAL_W-1:0]        want_total;
      logic [cpfr_pkg::TOTAL_W-1:0]        got_total;
      logic [cpfr_pkg::TICK_W-1:0]         elapsed;
      logic                                monitor_on;
      logic                                last_button;
      int                                  failures;

      function new();
         failures      = 0;
         timeout_ticks = cpfr_pkg::TIMEOUT_RESET;
         in_frame      = 1'b0;
         want_total    = '0;
         got_total     = '0;
         elapsed       = '0;
         monitor_on    = 1'b1;
         last_button   = 1'b0;
      endfunction

      function void report(string msg);
         failures++;
         if (failures <= MAX_SHOWN)
            $display("%0t: %s", $time, msg);
      endfunction

      function void restart_hunt();
         in_frame  = 1'b0;
         got_total = '0;
         elapsed   = '0;
      endfunction

      function void note_input(logic [cpfr_pkg::KIND_W-1:0] kind,
                               logic [cpfr_pkg::BYTE_W-1:0] rx, logic level);
         cpfr_pkg::result_type         r;
         logic [cpfr_pkg::TOTAL_W-1:0] slot;
         logic                         stored;
         r = '0;
         r.event_res = cpfr_pkg::EV_NONE;
         if (kind == cpfr_pkg::KIND_BYTE) begin
            if (!in_frame) begin
               if (rx[7] && rx[6:0] != '0) begin
                  want_total = rx[6:0];
                  in_frame   = 1'b1;
                  got_total  = '0;
                  elapsed    = '0;
               end
            end else if (rx[7]) begin
               r.event_res = cpfr_pkg::EV_BAD;
               restart_hunt();
            end else begin
               slot      = got_total;
               stored    = slot < cpfr_pkg::CAP_TOTAL;
               got_total = got_total + 1'b1;
               r.frame_count = (want_total > cpfr_pkg::CAP_TOTAL) ?
                               cpfr_pkg::FCOUNT_W'(cpfr_pkg::CAPACITY) :
                               cpfr_pkg::FCOUNT_W'(want_total);
               if (stored) begin
                  r.value_index = slot[cpfr_pkg::INDEX_W-1:0];
                  r.value_data  = rx[6:0];
               end
               if (got_total >= want_total) begin
                  r.event_res = cpfr_pkg::EV_DONE;
                  restart_hunt();
               end else if (stored) begin
                  r.event_res = cpfr_pkg::EV_STORED;
               end else begin
                  // past capacity: swallowed, nothing reported
                  r.frame_count = '0;
               end
            end
         end else if (kind == cpfr_pkg::KIND_TICK) begin
            if (elapsed != '1)
               elapsed = elapsed + 1'b1;
            if (elapsed > timeout_ticks) begin
               r.event_res = cpfr_pkg::EV_TIMEOUT;
               restart_hunt();
            end
         end else if (kind == cpfr_pkg::KIND_BUTTON) begin
            if (level && !last_button)
               monitor_on = !monitor_on;
            last_button = level;
            r.event_res = cpfr_pkg::EV_STATUS;
         end
         r.status_byte = monitor_on;
         expected_q.push_back(r);
      endfunction

      function void check_result(cpfr_pkg::result_type seen);
         cpfr_pkg::result_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("unexpected result: ev %0d idx %0d data %0d count %0d status %0d",
                             seen.event_res, seen.value_index, seen.value_data,
                             seen.frame_count, seen.status_byte));
            return;
         end
         want = expected_q.pop_front();
         if (seen.event_res !== want.event_res || seen.value_index !== want.value_index ||
             seen.value_data !== want.value_data || seen.frame_count !== want.frame_count ||
             seen.status_byte !== want.status_byte)
            report($sformatf({"mismatch: expected ev %0d idx %0d data %0d count %0d ",
                              "status %0d, got ev %0d idx %0d data %0d count %0d status %0d"},
                             want.event_res, want.value_index, want.value_data,
                             want.frame_count, want.status_byte, seen.event_res,
                             seen.value_index, seen.value_data, seen.frame_count,
                             seen.status_byte));
      endfunction
   endclass

   logic                              clock;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   logic [cpfr_pkg::KIND_W-1:0]       req_kind = cpfr_pkg::KIND_BYTE;
   logic [cpfr_pkg::BYTE_W-1:0]       req_rx_byte = '0;
   logic                              req_button_level = 1'b0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   logic [cpfr_pkg::EVENT_W-1:0]      rsp_event_res;
   logic [cpfr_pkg::INDEX_W-1:0]      rsp_value_index;
   logic [cpfr_pkg::DATA_W-1:0]       rsp_value_data;
   logic [cpfr_pkg::FCOUNT_W-1:0]     rsp_frame_count;
   logic                              rsp_status_byte;
   logic                              psel = 1'b0;
   logic                              penable = 1'b0;
   logic                              pwrite = 1'b0;
   logic [cpfr_pkg::CSR_ADDR_W-1:0]   paddr = '0;
   logic [cpfr_pkg::CSR_DATA_W-1:0]   pwdata = '0;
   logic [cpfr_pkg::CSR_DATA_W-1:0]   prdata;
   logic                              pready;

   frame_scoreboard scoreboard = new();
   int  items_sent  = 0;
   int  cur_timeout = int'(cpfr_pkg::TIMEOUT_RESET);
   bit  quiet       = 1'b0;
   bit  hold_armed  = 1'b0;
   bit  hold_done   = 1'b0;
   int  hold_left   = 0;

   count_prefixed_frame_receiver_unit DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_rx_byte      (req_rx_byte),
      .req_button_level (req_button_level),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_res    (rsp_event_res),
      .rsp_value_index  (rsp_value_index),
      .rsp_value_data   (rsp_value_data),
      .rsp_frame_count  (rsp_frame_count),
      .rsp_status_byte  (rsp_status_byte),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("simulation failed");
      $finish;
   end

   // result side: check each transaction, then pick the next stall
   always @(posedge clock) begin : rsp_side
      cpfr_pkg::result_type seen;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            seen.event_res   = rsp_event_res;
            seen.value_index = rsp_value_index;
            seen.value_data  = rsp_value_data;
            seen.frame_count = rsp_frame_count;
            seen.status_byte = rsp_status_byte;
            scoreboard.check_result(seen);
         end
         if (hold_left != 0) begin
            rsp_stall <= 1'b1;
            hold_left <= hold_left - 1;
         end else if (hold_armed && !hold_done) begin
            // long hold-off so the result queue fills and backs up the input
            rsp_stall <= 1'b1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
         end else begin
            rsp_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   function automatic logic [cpfr_pkg::BYTE_W-1:0] rand_byte();
      return cpfr_pkg::BYTE_W'($urandom);
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom);
   endfunction

   function automatic int frame_size();
      int r;
      r = $urandom_range(99);
      if (r < 60)
         return $urandom_range(6, 1);
      else if (r < 85)
         return $urandom_range(33, 7);
      else if (r < 95)
         return $urandom_range(64, 34);
      return $urandom_range(127, 65);
   endfunction

   task automatic send_item(input logic [cpfr_pkg::KIND_W-1:0] kind,
                            input logic [cpfr_pkg::BYTE_W-1:0] rx,
                            input logic level, input bit counted = 1'b1);
      while (!quiet && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_rx_byte      <= rx;
      req_button_level <= level;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      scoreboard.note_input(kind, rx, level);
      if (counted)
         items_sent++;
   endtask

   // header, then values with the odd tick or button sample mixed in;
   // stops early at stop_at, optionally with a top-bit byte there
   task automatic send_frame(input int count, input int stop_at, input bit bad);
      send_item(cpfr_pkg::KIND_BYTE, HEADER_FLAG | cpfr_pkg::BYTE_W'(count), rand_bit());
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(99) < 8)
            send_item(cpfr_pkg::KIND_TICK, rand_byte(), rand_bit());
         if ($urandom_range(99) < 3)
            send_item(cpfr_pkg::KIND_BUTTON, rand_byte(), rand_bit());
         if (i == stop_at) begin
            if (bad)
               send_item(cpfr_pkg::KIND_BYTE, HEADER_FLAG | rand_byte(), rand_bit());
            return;
         end
         send_item(cpfr_pkg::KIND_BYTE, {1'b0, 7'($urandom)}, rand_bit());
      end
   endtask

   task automatic send_noise();
      case ($urandom_range(5))
         0: send_item(KIND_SPARE, rand_byte(), rand_bit(), 1'b0);
         1: send_item(cpfr_pkg::KIND_BYTE, {1'b0, 7'($urandom)}, rand_bit(), 1'b0);
         2: send_item(cpfr_pkg::KIND_BYTE, HEADER_FLAG, rand_bit(), 1'b0);
         3: send_item(cpfr_pkg::KIND_BYTE, rand_byte(), rand_bit());
         4: send_item(cpfr_pkg::KIND_TICK, rand_byte(), rand_bit());
         default: send_item(cpfr_pkg::KIND_BUTTON, rand_byte(), rand_bit());
      endcase
   endtask

   task automatic random_phase(input int target);
      int start;
      int pick;
      int count;
      bit bad;
      start = items_sent;
      while (items_sent - start < target) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            send_frame(frame_size(), -1, 1'b0);
         end else if (pick < 80) begin
            count = frame_size();
            bad   = rand_bit();
            send_frame(count, $urandom_range(count - 1), bad);
            // let a cut-short frame run into the timeout when that is cheap
            if (!bad && cur_timeout <= 64)
               repeat (cur_timeout + 1)
                  send_item(cpfr_pkg::KIND_TICK, rand_byte(), rand_bit());
         end else begin
            send_noise();
         end
      end
   endtask

   // drop valid and wait for every outstanding result
   task automatic settle();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (scoreboard.expected_q.size() != 0 && waited < 2000) begin
         @(posedge clock);
         waited++;
      end
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_read_check(input logic [cpfr_pkg::TICK_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      paddr   <= cpfr_pkg::CSR_TIMEOUT_ADDR;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== cpfr_pkg::CSR_DATA_W'(value))
         scoreboard.report($sformatf("timeout readback: expected %0d, got %0d", value, prdata));
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_timeout(input logic [cpfr_pkg::TICK_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= cpfr_pkg::CSR_TIMEOUT_ADDR;
      pwdata  <= cpfr_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
      scoreboard.timeout_ticks = value;
      cur_timeout = int'(value);
      csr_read_check(value);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_read_check(cpfr_pkg::TIMEOUT_RESET);

      // button: press toggles, held or released does not
      send_item(cpfr_pkg::KIND_BUTTON, 8'h00, 1'b0);
      send_item(cpfr_pkg::KIND_BUTTON, 8'hFF, 1'b1);
      send_item(cpfr_pkg::KIND_BUTTON, 8'h00, 1'b1);
      send_item(cpfr_pkg::KIND_BUTTON, 8'hFF, 1'b0);
      send_item(cpfr_pkg::KIND_BUTTON, 8'h00, 1'b1);
      // hunting: plain bytes, zero-count header, unused kind
      send_item(cpfr_pkg::KIND_BYTE, 8'h00, 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h7F, 1'b1);
      send_item(cpfr_pkg::KIND_BYTE, HEADER_FLAG, 1'b0);
      send_item(KIND_SPARE, 8'hFF, 1'b1);
      // three-value frame
      send_item(cpfr_pkg::KIND_BYTE, 8'h83, 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h00, 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h7F, 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h55, 1'b0);
      // largest count, aborted by a top-bit byte
      send_item(cpfr_pkg::KIND_BYTE, 8'hFF, 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h2A, 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h80, 1'b0);
      // single-value frame, then a tick well under the timeout
      send_item(cpfr_pkg::KIND_BYTE, 8'h81, 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h11, 1'b0);
      send_item(cpfr_pkg::KIND_TICK, 8'hAA, 1'b1);
      settle();

      set_timeout(16'd1);
      send_item(cpfr_pkg::KIND_TICK, rand_byte(), rand_bit());
      send_item(cpfr_pkg::KIND_TICK, rand_byte(), rand_bit());
      random_phase(200);
      settle();

      // largest timeout: ticks in the middle of a frame never expire it
      set_timeout(16'hFFFF);
      send_item(cpfr_pkg::KIND_BYTE, 8'h84, 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h01, 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h02, 1'b0);
      repeat (50)
         send_item(cpfr_pkg::KIND_TICK, rand_byte(), rand_bit(), 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h03, 1'b0);
      send_item(cpfr_pkg::KIND_BYTE, 8'h04, 1'b0);
      random_phase(150);
      settle();

      quiet = 1'b1;
      set_timeout(cpfr_pkg::TICK_W'($urandom_range(30, 2)));
      random_phase(300);
      settle();
      quiet = 1'b0;

      set_timeout(cpfr_pkg::TICK_W'($urandom_range(300, 40)));
      hold_armed = 1'b1;
      random_phase(300);
      settle();

      if (scoreboard.expected_q.size() != 0)
         scoreboard.report($sformatf("%0d results never arrived",
                                     scoreboard.expected_q.size()));
      if (scoreboard.failures == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
